// ----- hdl/rbf_weighted_distance_sum_top_macros.svh -----
// Assertion macros for the multiquadric interpolator checker.
// Used by the checker file only; no other dependencies.
`ifndef RBF_WEIGHTED_DISTANCE_SUM_TOP_MACROS_SVH
`define RBF_WEIGHTED_DISTANCE_SUM_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RBF_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rbf check failed");
// Next-cycle implication checked on every clock edge outside reset.
`define RBF_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rbf check failed");
`endif

// ----- hdl/rbfwds_pkg.sv -----
// Shared types and constants for the multiquadric interpolator.
// No dependencies.
`default_nettype none
package rbfwds_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DIMS_DEF = 8;
  localparam int ROOT_PAIRS = 36;
  localparam int ROOT_W = 36;
  localparam int RAD_W = 56;
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [1:0] REG_NUM_POINTS = 2'd0;
  localparam logic [1:0] REG_NUM_DIMS = 2'd1;
  localparam logic [1:0] REG_SHAPE_SQ = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_RD, ST_DIFF, ST_SQ, ST_ACCD,
    ST_ROOT, ST_MUL, ST_ADD, ST_NEXT, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } root_ctl_t;
endpackage
`default_nettype wire

// ----- hdl/rbfwds_root.sv -----
// Bit-serial floor square root of radicand * 2^16, one result bit per cycle.
// Depends on rbfwds_pkg.
`default_nettype none
module rbfwds_root (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [rbfwds_pkg::RAD_W-1:0] radicand,
  output rbfwds_pkg::root_ctl_t ctl,
  output logic [rbfwds_pkg::ROOT_W-1:0] root
);
  // shifted operand: radicand followed by 16 zero bits (two per pair)
  logic [2*rbfwds_pkg::ROOT_PAIRS-1:0] opnd;
  logic [rbfwds_pkg::ROOT_W+1:0] rem;
  logic [5:0] count;
  logic busy;
  logic [rbfwds_pkg::ROOT_W+1:0] rem_sh;
  logic [rbfwds_pkg::ROOT_W+1:0] trial;

  always_comb begin
    rem_sh = {rem[rbfwds_pkg::ROOT_W-1:0], opnd[2*rbfwds_pkg::ROOT_PAIRS-1 -: 2]};
    trial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'(rbfwds_pkg::ROOT_PAIRS);
      opnd <= {radicand, 16'd0};
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      opnd <= {opnd[2*rbfwds_pkg::ROOT_PAIRS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[rbfwds_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[rbfwds_pkg::ROOT_W-2:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) busy <= 1'b0;
    end
  end

  assign ctl.start = start;
  assign ctl.busy = busy;
endmodule
`default_nettype wire

// ----- hdl/rbf_weighted_distance_sum_top.sv -----
// Multiquadric RBF interpolator: sum over centers of w * sqrt(|c - q|^2 + shape_sq).
// Loads and queries are taken only while idle. A last query then holds in_stall
// until the result is taken; each center runs a 4-state walk per coordinate and
// a 36-step root.
// Reset (synchronous, rst high) clears control, num_points 0, num_dims 1,
// shape_sq 0; stores stay undefined until written.
`default_nettype none
module rbf_weighted_distance_sum_top #(
  parameter int MAX_POINTS = rbfwds_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS = rbfwds_pkg::MAX_DIMS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [5:0] point_index,
  input  wire logic [2:0] dim_index,
  input  wire logic signed [31:0] value,
  input  wire logic last,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [47:0] result,
  output logic saturated
);
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int RAD_W_L = rbfwds_pkg::RAD_W;
  localparam logic signed [50:0] ACC_MAX_L = 51'(rbfwds_pkg::ACC_MAX);
  localparam logic signed [50:0] ACC_MIN_L = 51'(rbfwds_pkg::ACC_MIN);

  // Configuration registers.
  logic [6:0] num_points;
  logic [3:0] num_dims;
  logic [31:0] shape_sq;

  // Stores: center coordinates, weights, query coordinates.
  logic [31:0] center_mem [MAX_POINTS*MAX_DIMS];
  logic [31:0] weight_mem [MAX_POINTS];
  logic [31:0] query_mem [MAX_DIMS];

  rbfwds_pkg::state_t state, state_next;

  // Sequencer registers.
  logic [PCW-1:0] np_lim, pt;
  logic [DCW-1:0] nd_lim, dm;
  logic [31:0] c_rd, q_rd, w_rd;
  logic [32:0] mag;            // |difference| or |weight|
  logic [63:0] prod;           // registered product: mag squared, or weight times root
  logic [RAD_W_L-1:0] dsq;
  logic signed [47:0] acc;
  logic sat;
  logic w_neg;
  logic mul_phase;             // 0: mag*root_hi, 1: mag*root_lo
  logic [63:0] hi_part;

  logic root_start;
  rbfwds_pkg::root_ctl_t root_ctl;
  logic [rbfwds_pkg::ROOT_W-1:0] root;

  wire in_acc = in_valid && !in_stall;
  wire is_eval = in_acc && kind == rbfwds_pkg::KIND_QUERY && last;

  rbfwds_root u_root (
    .clk(clk), .rst(rst), .start(root_start), .radicand(dsq),
    .ctl(root_ctl), .root(root)
  );

  // Config writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= '0;
      num_dims <= 4'd1;
      shape_sq <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbfwds_pkg::REG_NUM_POINTS: num_points <= cfg_data[6:0];
        rbfwds_pkg::REG_NUM_DIMS:   num_dims <= cfg_data[3:0];
        rbfwds_pkg::REG_SHAPE_SQ:   shape_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store writes; drop out-of-range indices.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (kind == rbfwds_pkg::KIND_CENTER && 32'(point_index) < 32'(MAX_POINTS)
          && 32'(dim_index) < 32'(MAX_DIMS))
        center_mem[(PW+DW)'(point_index) * (PW+DW)'(MAX_DIMS) + (PW+DW)'(dim_index)] <= value;
      if (kind == rbfwds_pkg::KIND_WEIGHT && 32'(point_index) < 32'(MAX_POINTS))
        weight_mem[PW'(point_index)] <= value;
      if (kind == rbfwds_pkg::KIND_QUERY && 32'(dim_index) < 32'(MAX_DIMS))
        query_mem[DW'(dim_index)] <= value;
    end
  end

  // Registered store reads, addressed by the walk counters.
  always_ff @(posedge clk) begin
    c_rd <= center_mem[(PW+DW)'(pt) * (PW+DW)'(MAX_DIMS) + (PW+DW)'(dm)];
    q_rd <= query_mem[DW'(dm)];
    w_rd <= weight_mem[PW'(pt)];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rbfwds_pkg::ST_IDLE:  if (is_eval) state_next = rbfwds_pkg::ST_START;
      rbfwds_pkg::ST_START: state_next = (np_lim == 0) ? rbfwds_pkg::ST_OUT
                                                       : rbfwds_pkg::ST_RD;
      rbfwds_pkg::ST_RD:    state_next = (dm == nd_lim) ? rbfwds_pkg::ST_ROOT
                                                        : rbfwds_pkg::ST_DIFF;
      rbfwds_pkg::ST_DIFF:  state_next = rbfwds_pkg::ST_SQ;
      rbfwds_pkg::ST_SQ:    state_next = rbfwds_pkg::ST_ACCD;
      rbfwds_pkg::ST_ACCD:  state_next = rbfwds_pkg::ST_RD;
      rbfwds_pkg::ST_ROOT:  if (!root_ctl.start && !root_ctl.busy)
                              state_next = rbfwds_pkg::ST_MUL;
      rbfwds_pkg::ST_MUL:   if (mul_phase) state_next = rbfwds_pkg::ST_ADD;
      rbfwds_pkg::ST_ADD:   state_next = rbfwds_pkg::ST_NEXT;
      rbfwds_pkg::ST_NEXT:  state_next = (PCW'(pt + 1'b1) == np_lim) ? rbfwds_pkg::ST_OUT
                                                                     : rbfwds_pkg::ST_RD;
      rbfwds_pkg::ST_OUT:   if (!out_stall) state_next = rbfwds_pkg::ST_IDLE;
      default:              state_next = rbfwds_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = (state != rbfwds_pkg::ST_IDLE);
    out_valid = (state == rbfwds_pkg::ST_OUT);
  end

  // Shared multiplier: mag squared for coordinates, mag times root halves for weights.
  logic [32:0] mul_b;
  logic [63:0] mul_p;
  always_comb begin
    if (state == rbfwds_pkg::ST_MUL)
      mul_b = mul_phase ? 33'(root[15:0]) : 33'(root[35:16]);
    else
      mul_b = mag;
    mul_p = 64'(mag) * 64'(mul_b);
  end

  logic signed [33:0] diff;
  logic signed [50:0] term;
  logic signed [50:0] sum;
  always_comb begin
    diff = 34'(signed'(c_rd)) - 34'(signed'(q_rd));
    term = {1'b0, prod[49:0]};
    sum = 51'(acc) + (w_neg ? -term : term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbfwds_pkg::ST_IDLE;
      root_start <= 1'b0;
    end else begin
      state <= state_next;
      root_start <= 1'b0;
      unique case (state)
        rbfwds_pkg::ST_IDLE: if (is_eval) begin
          np_lim <= (32'(num_points) > 32'(MAX_POINTS)) ? PCW'(MAX_POINTS)
                                                        : PCW'(num_points);
          nd_lim <= (32'(num_dims) > 32'(MAX_DIMS)) ? DCW'(MAX_DIMS) : DCW'(num_dims);
          pt <= '0;
          dm <= '0;
          acc <= '0;
          sat <= 1'b0;
        end
        rbfwds_pkg::ST_START: dsq <= RAD_W_L'(shape_sq);
        rbfwds_pkg::ST_RD: if (dm == nd_lim) root_start <= 1'b1;
        rbfwds_pkg::ST_DIFF: mag <= diff[33] ? 33'(-diff) : 33'(diff);
        rbfwds_pkg::ST_SQ: prod <= mul_p;
        rbfwds_pkg::ST_ACCD: begin
          dsq <= dsq + RAD_W_L'(prod[63:16]);
          dm <= dm + 1'b1;
        end
        rbfwds_pkg::ST_ROOT: begin
          w_neg <= w_rd[31];
          mag <= w_rd[31] ? 33'(-34'(signed'(w_rd))) : 33'(w_rd);
          mul_phase <= 1'b0;
        end
        rbfwds_pkg::ST_MUL: begin
          if (!mul_phase) begin
            hi_part <= mul_p;
            mul_phase <= 1'b1;
          end else begin
            prod <= hi_part + (mul_p >> 16);
          end
        end
        rbfwds_pkg::ST_ADD: begin
          if (sum > ACC_MAX_L) begin
            acc <= rbfwds_pkg::ACC_MAX; sat <= 1'b1;
          end else if (sum < ACC_MIN_L) begin
            acc <= rbfwds_pkg::ACC_MIN; sat <= 1'b1;
          end else acc <= sum[47:0];
        end
        rbfwds_pkg::ST_NEXT: begin
          pt <= pt + 1'b1;
          dm <= '0;
          dsq <= RAD_W_L'(shape_sq);
        end
        default: ;
      endcase
    end
  end

  assign result = acc;
  assign saturated = sat;
endmodule
`default_nettype wire

// ----- hdl/rbfwds_checker.sv -----
// Port-level checker for the multiquadric interpolator, bound to the top level.
// Depends on rbf_weighted_distance_sum_top_macros.svh.
`default_nettype none
`include "rbf_weighted_distance_sum_top_macros.svh"
module rbfwds_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [47:0] result,
  input wire logic saturated
);
  `RBF_ASSERT_IMPL(no_req_during_result, clk, rst, out_valid, in_stall)
  `RBF_ASSERT_NEXT(result_holds, clk, rst, out_valid && out_stall,
                   out_valid && $stable(result) && $stable(saturated))
  `RBF_ASSERT_NEXT(idle_after_result, clk, rst, out_valid && !out_stall,
                   !out_valid && !in_stall)
  `RBF_ASSERT_NEXT(no_result_right_after_req, clk, rst, in_valid && !in_stall,
                   !out_valid)
endmodule
bind rbf_weighted_distance_sum_top rbfwds_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result(result),
  .saturated(saturated)
);
`default_nettype wire
